// ===== src/rledec_pkg.sv =====
// Package for the bitmap RLE run decoder: word types, codes and limits.
// Used by every module of the decoder; depends on nothing.
package rledec_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 4096;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;
  localparam int unsigned QUEUE_DEPTH    = 4;

  localparam logic [12:0] LINE_TOP = 13'h1FFF;
  localparam logic [1:0]  NIB_MASK = 2'h3;

  typedef enum logic [2:0] {
    PH_CMD  = 3'd0,
    PH_ARG  = 3'd1,
    PH_DX   = 3'd2,
    PH_DY   = 3'd3,
    PH_ABS  = 3'd4,
    PH_PAD  = 3'd5,
    PH_HALT = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    K_WRITE     = 3'd0,
    K_OK        = 3'd1,
    K_BAD_DELTA = 3'd2,
    K_BAD_ABS   = 3'd3,
    K_TRUNC     = 3'd4,
    K_TRAIL     = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_NIBBLE_MODE  = 2'd2,
    REG_TOP_FIRST    = 2'd3
  } cfg_idx_t;

  localparam logic [7:0] ESC_EOL   = 8'h00;
  localparam logic [7:0] ESC_EOB   = 8'h01;
  localparam logic [7:0] ESC_DELTA = 8'h02;

  typedef struct packed {
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic        nibble_mode;
    logic        top_first;
  } cfg_t;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       end_of_stream;
  } in_word_t;

  typedef struct packed {
    kind_t       kind;
    logic [11:0] row_index;
    logic [11:0] start_column;
    logic [7:0]  pixel_count;
    logic [7:0]  pixel_byte;
    logic        final_res;
  } out_word_t;

  typedef struct packed {
    logic        has_wr;
    logic [11:0] row_index;
    logic [11:0] start_column;
    logic [7:0]  pixel_count;
    logic [7:0]  pixel_byte;
    logic        has_st;
    kind_t       st_kind;
  } entry_t;

endpackage

// ===== src/rledec_front.sv =====
// Front end of the RLE decoder: takes one stream word per cycle while accept
// is high, tracks the command phase and position, and builds one queue entry of up to two results.
// Depends on rledec_pkg.
module rledec_front #(
  parameter int unsigned MAX_WIDTH  = rledec_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = rledec_pkg::MAX_HEIGHT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rledec_pkg::cfg_t    cfg,
  input  logic                accept,
  input  rledec_pkg::in_word_t word,
  output logic                push,
  output rledec_pkg::entry_t  entry
);
  import rledec_pkg::*;

  phase_t      phase_r, phase_nxt, phase_mid;
  logic [12:0] column_r, column_nxt;
  logic [12:0] line_r, line_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [7:0]  abs_left_r, abs_left_nxt;
  logic        pad_r, pad_nxt;

  logic [7:0]  b;
  logic        eos;
  logic [12:0] w, h, room, col_adv;
  logic        wr_req, wr_vis, st_hit, eos_hit;
  kind_t       st_kind;
  logic [7:0]  req_cnt, wr_cnt, take, abs_rem;
  logic [13:0] nx, ny;
  logic        delta_bad, abs_bad;
  logic [11:0] row;

  assign b   = word.stream_byte;
  assign eos = word.end_of_stream;
  assign w   = (32'(cfg.image_width) < MAX_WIDTH) ? cfg.image_width : 13'(MAX_WIDTH);
  assign h   = (32'(cfg.image_height) < MAX_HEIGHT) ? cfg.image_height : 13'(MAX_HEIGHT);

  assign room      = (column_r < w) ? (w - column_r) : 13'd0;
  assign nx        = {1'b0, column_r} + {6'd0, first_r};
  assign ny        = {1'b0, line_r} + {6'd0, b};
  assign delta_bad = (nx >= {1'b0, w}) || (ny > {1'b0, h});
  assign abs_bad   = {5'd0, b} > w;
  assign row       = cfg.top_first ? line_r[11:0] : 12'(h - 13'd1 - line_r);

  always_comb begin
    take = (cfg.nibble_mode && abs_left_r >= 8'd2) ? 8'd2 : 8'd1;
    if (take > abs_left_r) begin
      take = abs_left_r;
    end
    abs_rem = abs_left_r - take;
    wr_req  = (phase_r == PH_ABS) || (phase_r == PH_ARG && first_r != 8'd0);
    req_cnt = (phase_r == PH_ABS) ? take : first_r;
    wr_cnt  = ({5'd0, req_cnt} > room) ? room[7:0] : req_cnt;
    wr_vis  = wr_req && wr_cnt != 8'd0 && line_r < h;
    col_adv = column_r + {5'd0, wr_cnt};
    st_hit  = 1'b0;
    st_kind = K_OK;
    if (phase_r == PH_ARG && first_r == 8'd0 && b == ESC_EOB) begin
      st_hit  = 1'b1;
      st_kind = eos ? K_OK : K_TRAIL;
    end else if (phase_r == PH_ARG && first_r == 8'd0 && b != ESC_EOL &&
                 b != ESC_DELTA && abs_bad) begin
      st_hit  = 1'b1;
      st_kind = K_BAD_ABS;
    end else if (phase_r == PH_DY && delta_bad) begin
      st_hit  = 1'b1;
      st_kind = K_BAD_DELTA;
    end
  end

  always_comb begin
    phase_mid    = phase_r;
    column_nxt   = column_r;
    line_nxt     = line_r;
    first_nxt    = first_r;
    abs_left_nxt = abs_left_r;
    pad_nxt      = pad_r;
    case (phase_r)
      PH_CMD: begin
        first_nxt = b;
        phase_mid = PH_ARG;
      end
      PH_ARG: begin
        phase_mid = PH_CMD;
        if (first_r != 8'd0) begin
          column_nxt = col_adv;
        end else if (b == ESC_EOL) begin
          line_nxt   = (line_r != LINE_TOP) ? line_r + 13'd1 : line_r;
          column_nxt = 13'd0;
        end else if (b == ESC_DELTA) begin
          phase_mid = PH_DX;
        end else if (b != ESC_EOB && !abs_bad) begin
          abs_left_nxt = b;
          if (cfg.nibble_mode) begin
            pad_nxt = (b[1:0] == 2'd1) || (b[1:0] == 2'd2);
          end else begin
            pad_nxt = b[0];
          end
          phase_mid = PH_ABS;
        end
      end
      PH_DX: begin
        first_nxt = b;
        phase_mid = PH_DY;
      end
      PH_DY: begin
        if (!delta_bad) begin
          column_nxt = nx[12:0];
          line_nxt   = ny[12:0];
          phase_mid  = PH_CMD;
        end
      end
      PH_ABS: begin
        column_nxt   = col_adv;
        abs_left_nxt = abs_rem;
        if (abs_rem == 8'd0) begin
          phase_mid = pad_r ? PH_PAD : PH_CMD;
        end
      end
      PH_PAD: begin
        pad_nxt   = 1'b0;
        phase_mid = PH_CMD;
      end
      default: begin
        phase_mid = PH_HALT;
      end
    endcase
    phase_nxt = st_hit ? PH_HALT : phase_mid;
    if (eos) begin
      phase_nxt    = PH_CMD;
      column_nxt   = 13'd0;
      line_nxt     = 13'd0;
      first_nxt    = 8'd0;
      abs_left_nxt = 8'd0;
      pad_nxt      = 1'b0;
    end
  end

  always_comb begin
    eos_hit            = eos && !st_hit && phase_r != PH_HALT;
    entry.has_wr       = wr_vis;
    entry.row_index    = row;
    entry.start_column = column_r[11:0];
    entry.pixel_count  = wr_cnt;
    entry.pixel_byte   = b;
    entry.has_st       = st_hit || eos_hit;
    if (st_hit) begin
      entry.st_kind = st_kind;
    end else if (phase_mid == PH_CMD || phase_mid == PH_PAD) begin
      entry.st_kind = K_OK;
    end else begin
      entry.st_kind = K_TRUNC;
    end
    push = accept && (wr_vis || st_hit || eos_hit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_CMD;
      column_r   <= 13'd0;
      line_r     <= 13'd0;
      first_r    <= 8'd0;
      abs_left_r <= 8'd0;
      pad_r      <= 1'b0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      column_r   <= column_nxt;
      line_r     <= line_nxt;
      first_r    <= first_nxt;
      abs_left_r <= abs_left_nxt;
      pad_r      <= pad_nxt;
    end
  end

endmodule

// ===== src/rledec_queue.sv =====
// Short entry queue between the decoder front and the result back end.
// Depends on rledec_pkg for the entry type.
module rledec_queue #(
  parameter int unsigned DEPTH = rledec_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rledec_pkg::entry_t push_entry,
  input  logic               pop,
  output rledec_pkg::entry_t head,
  output logic               empty,
  output logic               full
);
  import rledec_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  entry_t          slots_r [DEPTH];
  logic [PW-1:0]   wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign empty = (count_r == CW'(0));
  assign full  = (count_r == CW'(DEPTH));
  assign head  = slots_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? PW'(0) : wptr_r + PW'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? PW'(0) : rptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wptr_r] <= push_entry;
    end
  end

endmodule

// ===== src/rledec_back.sv =====
// Back end of the RLE decoder: presents the head entry's results one word at
// a time, pixel write first, and pops the entry after its last word.
// Depends on rledec_pkg.
module rledec_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rledec_pkg::entry_t    head,
  input  logic                  empty,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rledec_pkg::out_word_t out_word
);
  import rledec_pkg::*;

  logic sel_r, sel_nxt;
  logic cur_st, last, take;

  always_comb begin
    out_valid = !empty;
    cur_st    = !head.has_wr || sel_r;
    last      = cur_st || !head.has_st;
    take      = out_valid && !out_stall;
    pop       = take && last;
    sel_nxt   = take ? !last : sel_r;
    if (cur_st) begin
      out_word.kind         = head.st_kind;
      out_word.row_index    = 12'd0;
      out_word.start_column = 12'd0;
      out_word.pixel_count  = 8'd0;
      out_word.pixel_byte   = 8'd0;
    end else begin
      out_word.kind         = K_WRITE;
      out_word.row_index    = head.row_index;
      out_word.start_column = head.start_column;
      out_word.pixel_count  = head.pixel_count;
      out_word.pixel_byte   = head.pixel_byte;
    end
    out_word.final_res = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
    end
  end

endmodule

// ===== src/bitmap_rle_run_decoder_core.sv =====
// Top level of the bitmap RLE8/RLE4 run decoder: configuration registers,
// decoder front, entry queue and result back end.
// Depends on rledec_pkg, rledec_front, rledec_queue and rledec_back.
//
//   channel  direction  handshake          word
//   in_      input      in_valid/in_stall  stream_byte, end_of_stream
//   out_     output     out_valid/out_stall kind, row, column, count, byte, final
//   cfg_     input      cfg_valid/cfg_ready index and 13-bit data
//
// One stream word is taken every cycle while the four-entry queue has room.
// Each word yields at most two results, drained at one result per cycle while out_stall is low.
// A stalled output only stops input once the queue fills.
// Reset is synchronous; after it the block takes words at once.
module bitmap_rle_run_decoder_core #(
  parameter int unsigned MAX_WIDTH  = rledec_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = rledec_pkg::MAX_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  rledec_pkg::in_word_t  in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rledec_pkg::out_word_t out_word,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  rledec_pkg::cfg_idx_t  cfg_index,
  input  logic [12:0]           cfg_data
);
  import rledec_pkg::*;

  cfg_t   cfg_r;
  entry_t push_entry, head;
  logic   push, pop, empty, full, in_take;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width  <= 13'd1;
      cfg_r.image_height <= 13'd1;
      cfg_r.nibble_mode  <= 1'b0;
      cfg_r.top_first    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  cfg_r.image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_data;
        REG_NIBBLE_MODE:  cfg_r.nibble_mode  <= cfg_data[0];
        REG_TOP_FIRST:    cfg_r.top_first    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  rledec_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .accept (in_take),
    .word   (in_word),
    .push   (push),
    .entry  (push_entry)
  );

  rledec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  rledec_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

// ===== src/rledec_checker.sv =====
// Port-level checks for the RLE decoder top level, with the bind that
// attaches them. Depends on rledec_pkg and bitmap_rle_run_decoder_core.
module rledec_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input rledec_pkg::out_word_t out_word
);
  import rledec_pkg::*;

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("Outputs not idle after reset.");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("Stalled result word changed.");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.kind != K_WRITE |-> out_word.final_res)
    else $error("Status result is not the last of its byte.");

  a_write_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.kind == K_WRITE |-> out_word.pixel_count != 8'd0)
    else $error("Pixel write with zero count.");

endmodule

bind bitmap_rle_run_decoder_core rledec_checker u_rledec_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
